### design/wheel_odometry_with_sensor_fusion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wheel odometry block
// Shared property templates used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ODOMETRY_WITH_SENSOR_FUSION_DEFINES_SVH
`define WHEEL_ODOMETRY_WITH_SENSOR_FUSION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WODO_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wodo check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WODO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wodo check failed");

`endif

### design/wodo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wodo_pkg
// Types, constants and helper functions of the wheel odometry block.
// ----------------------------------------------------------------------------
package wodo_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // Divisors: 2*pi in Q16.16 and centidegrees in one turn.
   localparam logic signed [32:0] TWO_PI_Q16        = 33'sd411775;
   localparam logic signed [32:0] CENTIDEG_PER_TURN = 33'sd36000;

   // Heading rules work on degrees scaled by 65536.
   localparam logic [8:0]  DEG_PER_TURN    = 9'd360;
   localparam logic [24:0] EDGE_HIGH_LIMIT = 25'd21626880; // 330 degrees
   localparam logic [24:0] EDGE_LOW_LIMIT  = 25'd1966080;  // 30 degrees
   localparam logic [8:0]  SPLIT_DEG       = 9'd40;

   typedef enum logic [1:0] {
      CSR_LEFT_HALF_TRACK  = 2'd0,
      CSR_RIGHT_HALF_TRACK = 2'd1,
      CSR_WHEEL_CIRC       = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRAV_L_MUL,
      ST_TRAV_L_DIV,
      ST_TRAV_R_MUL,
      ST_TRAV_R_DIV,
      ST_RATE_DIV,
      ST_TURN_DIV,
      ST_HALF_DIV,
      ST_HALF_COR,
      ST_GAIN_DIV,
      ST_CHORD_MUL,
      ST_ARM_MUL,
      ST_POSE_COR,
      ST_X_MUL,
      ST_Y_MUL,
      ST_DONE
   } state_type;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic [29:0] atan_turn32(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051D;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2E;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2F9;
         5'd15: v = 30'h0000517C;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A2F;
         5'd19: v = 30'h00000517;
         5'd20: v = 30'h0000028B;
         5'd21: v = 30'h00000145;
         5'd22: v = 30'h000000A2;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000028;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000002;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   // Clamp a wide signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] r;
      if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -72'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

### design/wodo_sdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wodo_sdiv
// Bit-serial restoring divider, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
module wodo_sdiv (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [32:0] den,
   output logic               done,
   output logic signed [64:0] quo
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [63:0] num_mag;
   logic [32:0] den_mag;
   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      num_mag = num[63] ? 64'(-num) : 64'(num);
      den_mag = den[32] ? 33'(-den) : 33'(den);
      trial   = {rem_ff, q_ff[63]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num_mag;
         rem_in  = '0;
         den_in  = den_mag[31:0];
         neg_in  = num[63] ^ den[32];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

### design/wodo_smul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wodo_smul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wodo_smul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] a,
   input  logic signed [33:0] b,
   output logic               done,
   output logic signed [67:0] prod
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [33:0] a_ff, a_in;
   logic [67:0] p_ff, p_in;
   logic [33:0] a_mag;
   logic [33:0] b_mag;
   logic [34:0] sum;

   always_comb begin
      a_mag   = a[33] ? 34'(-a) : 34'(a);
      b_mag   = b[33] ? 34'(-b) : 34'(b);
      sum     = {1'b0, p_ff[67:34]} + (p_ff[0] ? {1'b0, a_ff} : 35'd0);
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a_mag;
         p_in    = {34'd0, b_mag};
         neg_in  = a[33] ^ b[33];
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[33:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      p_ff   <= p_in;
   end

   assign done = done_ff;
   assign prod = neg_ff ? -$signed(p_ff) : $signed(p_ff);

endmodule

### design/wodo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wodo_cordic
// Iterative rotation-mode CORDIC giving Q30 sine and cosine, one step a cycle.
// ----------------------------------------------------------------------------
module wodo_cordic
   import wodo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [33:0] sin_out,
   output logic signed [33:0] cos_out
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [4:0]         idx_ff, idx_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic               fold;
   logic [31:0]        folded;
   logic signed [33:0] dx;
   logic signed [33:0] dy;
   logic signed [33:0] step;

   always_comb begin
      // Angles in the left half-plane are turned by half a turn.
      fold    = angle[31] ^ angle[30];
      folded  = fold ? {~angle[31], angle[30:0]} : angle;
      dx      = y_ff >>> idx_ff;
      dy      = x_ff >>> idx_ff;
      step    = $signed({4'd0, atan_turn32(idx_ff)});
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         neg_in  = fold;
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         z_in    = 34'($signed(folded));
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step;
         end
         idx_in = idx_ff + 5'd1;
         if (idx_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done    = done_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;

endmodule

### design/wheel_odometry_with_sensor_fusion.sv
`timescale 1ns / 1ps
// Throughput: one beat at a time; the next request is taken as soon as the
// sequencer is idle again, even while the previous response waits.
// The shared 64-step serial divider is used up to six times per beat.
// Synchronous active-high reset clears pose, last angles and handshake state
// and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// wheel_odometry_with_sensor_fusion
// Two-wheel arc odometry with GPS position and inertial heading fusion.
// ----------------------------------------------------------------------------
`include "wheel_odometry_with_sensor_fusion_defines.svh"

module wheel_odometry_with_sensor_fusion
   import wodo_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_left_angle,
   input  logic signed [31:0] req_right_angle,
   input  logic [6:0]         req_gps_a_quality,
   input  logic signed [31:0] req_gps_a_x,
   input  logic signed [31:0] req_gps_a_y,
   input  logic [6:0]         req_gps_b_quality,
   input  logic signed [31:0] req_gps_b_x,
   input  logic signed [31:0] req_gps_b_y,
   input  logic [15:0]        req_imu_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_odo_x,
   output logic signed [31:0] rsp_odo_y,
   output logic [15:0]        rsp_odo_heading,
   output logic signed [31:0] rsp_fused_x,
   output logic signed [31:0] rsp_fused_y,
   output logic [15:0]        rsp_fused_heading
);

   // Sequencer and handshake state.
   state_type state_ff, state_in;
   logic      go_ff, go_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [15:0] lht_ff, lht_in;
   logic [15:0] rht_ff, rht_in;
   logic [15:0] circ_ff, circ_in;

   // Persistent state.
   logic signed [31:0]     last_l_ff, last_l_in;
   logic signed [31:0]     last_r_ff, last_r_in;
   logic signed [31:0]     pose_x_ff, pose_x_in;
   logic signed [31:0]     pose_y_ff, pose_y_in;
   logic [ANGLE_BITS-1:0]  pose_h_ff, pose_h_in;

   // Captured beat.
   logic signed [32:0] diff_l_ff, diff_l_in;
   logic signed [32:0] diff_r_ff, diff_r_in;
   logic [6:0]         qa_ff, qa_in;
   logic [6:0]         qb_ff, qb_in;
   logic signed [31:0] ax_ff, ax_in;
   logic signed [31:0] ay_ff, ay_in;
   logic signed [31:0] bx_ff, bx_in;
   logic signed [31:0] by_ff, by_in;
   logic [15:0]        imu_ff, imu_in;

   // Working values of one step.
   logic signed [31:0]    dl_ff, dl_in;
   logic signed [31:0]    dr_ff, dr_in;
   logic signed [31:0]    r_ff, r_in;
   logic [ANGLE_BITS-1:0] dh_ff, dh_in;
   logic                  arc_ff, arc_in;
   logic [31:0]           h_ff, h_in;
   logic signed [33:0]    sh_ff, sh_in;
   logic signed [33:0]    k_ff, k_in;
   logic signed [37:0]    dk_ff, dk_in;
   logic signed [33:0]    move_ff, move_in;
   logic signed [31:0]    x_new_ff, x_new_in;
   logic signed [31:0]    y_new_ff, y_new_in;

   // Result register.
   logic signed [31:0] odo_x_ff, odo_x_in;
   logic signed [31:0] odo_y_ff, odo_y_in;
   logic [15:0]        odo_h_ff, odo_h_in;
   logic signed [31:0] fx_ff, fx_in;
   logic signed [31:0] fy_ff, fy_in;
   logic [15:0]        fh_ff, fh_in;

   // Arithmetic units.
   logic               div_start, div_done;
   logic signed [63:0] div_num;
   logic signed [32:0] div_den;
   logic signed [64:0] div_quo;
   logic               mul_start, mul_done;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_prod;
   logic               cor_start, cor_done;
   logic [31:0]        cor_angle;
   logic signed [33:0] cor_sin, cor_cos;
   logic               unit_done;
   logic               accept;
   logic               out_load;

   // Shared combinational terms.
   logic [16:0]           track_sum;
   logic signed [32:0]    wheel_diff;
   logic [31:0]           pose_turn;
   logic signed [47:0]    chord_sum;
   logic [ANGLE_BITS-1:0] h_next;
   logic [31:0]           turn_next;
   logic [15:0]           o16;
   logic [24:0]           ho;
   logic [24:0]           hi;
   logic [8:0]            od;
   logic [8:0]            idg;
   logic [8:0]            deg_diff;
   logic [16:0]           head_sum;
   logic                  gps_close;
   logic signed [32:0]    gx_sum;
   logic signed [32:0]    gy_sum;
   logic signed [31:0]    gx;
   logic signed [31:0]    gy;
   logic signed [32:0]    fx_sum;
   logic signed [32:0]    fy_sum;

   wodo_sdiv u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   wodo_smul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   wodo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   assign unit_done = div_done | mul_done | cor_done;
   assign accept    = req_valid & req_ready;
   assign track_sum = {1'b0, lht_ff} + {1'b0, rht_ff};
   assign pose_turn = 32'(pose_h_ff) << (32 - ANGLE_BITS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (accept) state_in = ST_TRAV_L_MUL;
         ST_TRAV_L_MUL: if (unit_done) state_in = ST_TRAV_L_DIV;
         ST_TRAV_L_DIV: if (unit_done) state_in = ST_TRAV_R_MUL;
         ST_TRAV_R_MUL: if (unit_done) state_in = ST_TRAV_R_DIV;
         ST_TRAV_R_DIV: begin
            if (unit_done) state_in = (track_sum == 17'd0) ? ST_POSE_COR : ST_RATE_DIV;
         end
         ST_RATE_DIV:   if (unit_done) state_in = ST_TURN_DIV;
         ST_TURN_DIV: begin
            if (unit_done) state_in = (div_quo == 65'sd0) ? ST_POSE_COR : ST_HALF_DIV;
         end
         ST_HALF_DIV:   if (unit_done) state_in = ST_HALF_COR;
         ST_HALF_COR:   if (unit_done) state_in = ST_GAIN_DIV;
         ST_GAIN_DIV:   if (unit_done) state_in = ST_CHORD_MUL;
         ST_CHORD_MUL:  if (unit_done) state_in = ST_ARM_MUL;
         ST_ARM_MUL:    if (unit_done) state_in = ST_POSE_COR;
         ST_POSE_COR:   if (unit_done) state_in = ST_X_MUL;
         ST_X_MUL:      if (unit_done) state_in = ST_Y_MUL;
         ST_Y_MUL:      if (unit_done) state_in = ST_DONE;
         ST_DONE:       if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: each unit is launched in the first cycle of its state.
   always_comb begin
      div_start = 1'b0;
      mul_start = 1'b0;
      cor_start = 1'b0;
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: req_ready = 1'b1;
         ST_TRAV_L_DIV, ST_TRAV_R_DIV, ST_RATE_DIV, ST_TURN_DIV, ST_HALF_DIV,
         ST_GAIN_DIV: div_start = go_ff;
         ST_TRAV_L_MUL, ST_TRAV_R_MUL, ST_CHORD_MUL, ST_ARM_MUL, ST_X_MUL,
         ST_Y_MUL: mul_start = go_ff;
         ST_HALF_COR, ST_POSE_COR: cor_start = go_ff;
         ST_DONE: out_load = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   // Operand selection for the shared units.
   always_comb begin
      wheel_diff = 33'(dr_ff) - 33'(dl_ff);
      div_num    = '0;
      div_den    = 33'sd1;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         ST_TRAV_L_DIV, ST_TRAV_R_DIV: begin
            div_num = $signed({mul_prod[55:0], 8'd0});
            div_den = CENTIDEG_PER_TURN;
         end
         ST_RATE_DIV: begin
            div_num = $signed({{23{wheel_diff[32]}}, wheel_diff, 8'd0});
            div_den = $signed({16'd0, track_sum});
         end
         ST_TURN_DIV: begin
            div_num = 64'(r_ff) <<< ANGLE_BITS;
            div_den = TWO_PI_Q16;
         end
         ST_HALF_DIV: begin
            div_num = 64'(r_ff) <<< 31;
            div_den = TWO_PI_Q16;
         end
         ST_GAIN_DIV: begin
            div_num = 64'(sh_ff) <<< 17;
            div_den = 33'(r_ff);
         end
         ST_TRAV_L_MUL: begin
            mul_a = 34'(diff_l_ff);
            mul_b = $signed({18'd0, circ_ff});
         end
         ST_TRAV_R_MUL: begin
            mul_a = 34'(diff_r_ff);
            mul_b = $signed({18'd0, circ_ff});
         end
         ST_CHORD_MUL: begin
            mul_a = 34'(dl_ff);
            mul_b = k_ff;
         end
         ST_ARM_MUL: begin
            mul_a = $signed({18'd0, lht_ff});
            mul_b = sh_ff;
         end
         ST_X_MUL: begin
            mul_a = move_ff;
            mul_b = cor_sin;
         end
         ST_Y_MUL: begin
            mul_a = move_ff;
            mul_b = cor_cos;
         end
         default: begin
            div_num = '0;
         end
      endcase
      // The half-angle rotation only applies on the arc path.
      cor_angle = (state_ff == ST_HALF_COR) ? h_ff : (pose_turn + (arc_ff ? h_ff : 32'd0));
   end

   // Result fusion, evaluated while the finished step sits in its last state.
   always_comb begin
      h_next    = arc_ff ? (pose_h_ff + dh_ff) : pose_h_ff;
      turn_next = 32'(h_next) << (32 - ANGLE_BITS);
      o16       = turn_next[31:16];
      ho        = 25'(o16) * 25'(DEG_PER_TURN);
      hi        = 25'(imu_ff) * 25'(DEG_PER_TURN);
      od        = ho[24:16];
      idg       = hi[24:16];
      deg_diff  = (od > idg) ? (od - idg) : (idg - od);
      head_sum  = {1'b0, o16} + {1'b0, imu_ff};
      // Wrap-edge rules first, then the 40 degree split, then the mean.
      if (ho > EDGE_HIGH_LIMIT && hi < EDGE_LOW_LIMIT) begin
         fh_in = o16;
      end else if (ho < EDGE_LOW_LIMIT && hi > EDGE_HIGH_LIMIT) begin
         fh_in = imu_ff;
      end else if (deg_diff > SPLIT_DEG) begin
         fh_in = o16;
      end else begin
         fh_in = head_sum[16:1];
      end

      // Qualities within one of each other: average the two fixes.
      gps_close = ({1'b0, qa_ff} + 8'd2 > {1'b0, qb_ff}) &&
                  ({1'b0, qb_ff} + 8'd2 > {1'b0, qa_ff});
      gx_sum    = 33'(ax_ff) + 33'(bx_ff);
      gy_sum    = 33'(ay_ff) + 33'(by_ff);
      if (gps_close) begin
         gx = gx_sum[32:1];
         gy = gy_sum[32:1];
      end else if (qa_ff > qb_ff) begin
         gx = ax_ff;
         gy = ay_ff;
      end else begin
         gx = bx_ff;
         gy = by_ff;
      end
      fx_sum   = 33'(x_new_ff) + 33'(gx);
      fy_sum   = 33'(y_new_ff) + 33'(gy);
      fx_in    = fx_sum[32:1];
      fy_in    = fy_sum[32:1];
      odo_x_in = x_new_ff;
      odo_y_in = y_new_ff;
      odo_h_in = o16;
   end

   // Datapath register updates.
   always_comb begin
      chord_sum    = 48'(dk_ff) + 48'($signed(mul_prod[67:21]));
      go_in        = (state_in != state_ff);
      rsp_valid_in = rsp_valid_ff;
      lht_in       = lht_ff;
      rht_in       = rht_ff;
      circ_in      = circ_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      pose_h_in    = pose_h_ff;
      diff_l_in    = diff_l_ff;
      diff_r_in    = diff_r_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      imu_in       = imu_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      r_in         = r_ff;
      dh_in        = dh_ff;
      arc_in       = arc_ff;
      h_in         = h_ff;
      sh_in        = sh_ff;
      k_in         = k_ff;
      dk_in        = dk_ff;
      move_in      = move_ff;
      x_new_in     = x_new_ff;
      y_new_in     = y_new_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT_HALF_TRACK:  lht_in  = csr_wdata;
            CSR_RIGHT_HALF_TRACK: rht_in  = csr_wdata;
            CSR_WHEEL_CIRC:       circ_in = csr_wdata;
            default:              lht_in  = lht_ff;
         endcase
      end

      if (accept) begin
         diff_l_in = 33'(req_left_angle) - 33'(last_l_ff);
         diff_r_in = 33'(req_right_angle) - 33'(last_r_ff);
         last_l_in = req_left_angle;
         last_r_in = req_right_angle;
         qa_in     = req_gps_a_quality;
         qb_in     = req_gps_b_quality;
         ax_in     = req_gps_a_x;
         ay_in     = req_gps_a_y;
         bx_in     = req_gps_b_x;
         by_in     = req_gps_b_y;
         imu_in    = req_imu_heading;
      end

      if (unit_done) begin
         case (state_ff)
            ST_TRAV_L_DIV: dl_in = sat32(72'(div_quo));
            ST_TRAV_R_DIV: begin
               dr_in   = sat32(72'(div_quo));
               arc_in  = 1'b0;
               move_in = 34'(dl_ff);
            end
            ST_RATE_DIV: r_in = sat32(72'(div_quo));
            ST_TURN_DIV: begin
               arc_in = (div_quo != 65'sd0);
               dh_in  = div_quo[ANGLE_BITS-1:0];
            end
            ST_HALF_DIV:  h_in  = div_quo[31:0];
            ST_HALF_COR:  sh_in = cor_sin;
            ST_GAIN_DIV:  k_in  = div_quo[33:0];
            ST_CHORD_MUL: dk_in = $signed(mul_prod[67:30]);
            ST_ARM_MUL:   move_in = chord_sum[33:0];
            ST_X_MUL: x_new_in = sat32(72'(pose_x_ff) + 72'($signed(mul_prod[67:30])));
            ST_Y_MUL: y_new_in = sat32(72'(pose_y_ff) + 72'($signed(mul_prod[67:30])));
            default:  dl_in = dl_ff;
         endcase
      end

      if (out_load) begin
         pose_x_in    = x_new_ff;
         pose_y_in    = y_new_ff;
         pose_h_in    = h_next;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lht_ff       <= 16'd1280;
         rht_ff       <= 16'd1280;
         circ_ff      <= 16'd5228;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         lht_ff       <= lht_in;
         rht_ff       <= rht_in;
         circ_ff      <= circ_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_h_ff    <= pose_h_in;
      end
      diff_l_ff <= diff_l_in;
      diff_r_ff <= diff_r_in;
      qa_ff     <= qa_in;
      qb_ff     <= qb_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      imu_ff    <= imu_in;
      dl_ff     <= dl_in;
      dr_ff     <= dr_in;
      r_ff      <= r_in;
      dh_ff     <= dh_in;
      arc_ff    <= arc_in;
      h_ff      <= h_in;
      sh_ff     <= sh_in;
      k_ff      <= k_in;
      dk_ff     <= dk_in;
      move_ff   <= move_in;
      x_new_ff  <= x_new_in;
      y_new_ff  <= y_new_in;
      if (out_load) begin
         odo_x_ff <= odo_x_in;
         odo_y_ff <= odo_y_in;
         odo_h_ff <= odo_h_in;
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
         fh_ff    <= fh_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_odo_x         = odo_x_ff;
   assign rsp_odo_y         = odo_y_ff;
   assign rsp_odo_heading   = odo_h_ff;
   assign rsp_fused_x       = fx_ff;
   assign rsp_fused_y       = fy_ff;
   assign rsp_fused_heading = fh_ff;

   `WODO_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)
   `WODO_ASSERT_IMPL(a_one_unit_launched, clock, reset, 1'b1, $onehot0({div_start, mul_start, cor_start}))
   `WODO_ASSERT_NEXT(a_load_shows_result, clock, reset, out_load, rsp_valid_ff)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry block testbench
// Drives encoder, GPS and inertial beats through the request channel under
// random back-pressure on both sides and checks every response beat against
// an in-bench fixed-point model of the arc odometry and fusion rules.
// ----------------------------------------------------------------------------
module testbench
   import wodo_pkg::*;
;

   typedef logic signed [127:0] wide_type;

   // Register index that the block has no register behind; writes must vanish.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int  ROT_STEPS   = 30;
   localparam longint ROT_GAIN = 64'sd652032874;
   localparam longint TURN_Q16 = 64'sd411775;
   // Arctangent of 2^-i, in units of 2^32 per turn.
   localparam longint ROT_ATAN [ROT_STEPS] = '{
      'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
      'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
      'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

   typedef struct {
      logic signed [31:0] left_angle, right_angle;
      logic [6:0]         qa;
      logic signed [31:0] ax, ay;
      logic [6:0]         qb;
      logic signed [31:0] bx, by;
      logic [15:0]        imu;
   } sensor_beat_type;

   typedef struct {
      logic signed [31:0] odo_x, odo_y;
      logic [15:0]        odo_heading;
      logic signed [31:0] fused_x, fused_y;
      logic [15:0]        fused_heading;
   } pose_beat_type;

   // ------------------------------------------------------------------------
   // Pose scoreboard: holds its own copy of the odometry state and the track
   // registers, and queues the pose each accepted sensor beat should give.
   // ------------------------------------------------------------------------
   class pose_scoreboard;
      longint     half_left = 1280, half_right = 1280, circ = 5228;
      longint     prev_left = 0, prev_right = 0, px = 0, py = 0;
      logic [15:0] heading = 0;
      pose_beat_type expected_poses[$];
      int         mismatches = 0, checked = 0, arcs = 0, straights = 0;

      function longint clamp32(wide_type v);
         if (v > 128'sd2147483647) return 64'sd2147483647;
         if (v < -128'sd2147483648) return -64'sd2147483648;
         return longint'(v);
      endfunction

      function void rotate(logic [31:0] a, output longint s, output longint c);
         longint x, y, z, dx, dy;
         bit     flip;
         flip = 0;
         x = ROT_GAIN;
         y = 0;
         if (a >= 32'h40000000 && a < 32'hC0000000) begin
            a = a - 32'h80000000;
            flip = 1;
         end
         z = longint'(signed'(a));
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ROT_ATAN[i];
            end else begin
               x += dx; y -= dy; z += ROT_ATAN[i];
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         if (idx == CSR_LEFT_HALF_TRACK) half_left = longint'(val);
         else if (idx == CSR_RIGHT_HALF_TRACK) half_right = longint'(val);
         else if (idx == CSR_WHEEL_CIRC) circ = longint'(val);
      endfunction

      function void note_request(sensor_beat_type b);
         longint dl, dr, tsum, r, dh, s, c, sh, ch, k, gx, gy, ho, hi, od, idg, df;
         wide_type chord;
         logic [31:0] half;
         logic [15:0] fh;
         pose_beat_type p;
         dl = clamp32((wide_type'(longint'(b.left_angle)) - prev_left) * circ * 256 / 36000);
         dr = clamp32((wide_type'(longint'(b.right_angle)) - prev_right) * circ * 256 / 36000);
         prev_left  = longint'(b.left_angle);
         prev_right = longint'(b.right_angle);
         tsum = half_left + half_right;
         r = 0;
         if (tsum != 0) r = clamp32(wide_type'(dr - dl) * 256 / tsum);
         dh = r * 65536 / TURN_Q16;
         if (dh == 0) begin
            straights++;
            rotate({heading, 16'h0}, s, c);
            px = clamp32(wide_type'(px) + ((wide_type'(dl) * s) >>> 30));
            py = clamp32(wide_type'(py) + ((wide_type'(dl) * c) >>> 30));
         end else begin
            arcs++;
            // Half of the heading change, as a 2^32-per-turn angle.
            half = 32'(r * (64'sd1 <<< 31) / TURN_Q16);
            rotate(half, sh, ch);
            k = (2 * sh * 65536) / r;
            chord = ((wide_type'(dl) * k) >>> 30) +
                    ((wide_type'(2 * half_left * 256) * sh) >>> 30);
            rotate({heading, 16'h0} + half, s, c);
            px = clamp32(wide_type'(px) + ((chord * s) >>> 30));
            py = clamp32(wide_type'(py) + ((chord * c) >>> 30));
            heading = heading + dh[15:0];
         end
         if (int'(b.qa) + 2 > int'(b.qb) && int'(b.qb) + 2 > int'(b.qa)) begin
            gx = (longint'(b.ax) + longint'(b.bx)) >>> 1;
            gy = (longint'(b.ay) + longint'(b.by)) >>> 1;
         end else if (b.qa > b.qb) begin
            gx = longint'(b.ax); gy = longint'(b.ay);
         end else begin
            gx = longint'(b.bx); gy = longint'(b.by);
         end
         // Heading fusion: wrap-edge rules first, then the 40 degree split.
         ho = longint'(heading) * 360;
         hi = longint'(b.imu) * 360;
         if (ho > 330 * 65536 && hi < 30 * 65536) fh = heading;
         else if (ho < 30 * 65536 && hi > 330 * 65536) fh = b.imu;
         else begin
            od  = ho >> 16;
            idg = hi >> 16;
            df  = od > idg ? od - idg : idg - od;
            fh  = (df > 40) ? heading : 16'((longint'(heading) + longint'(b.imu)) >> 1);
         end
         p.odo_x = 32'(px);
         p.odo_y = 32'(py);
         p.odo_heading = heading;
         p.fused_x = 32'((px + gx) >>> 1);
         p.fused_y = 32'((py + gy) >>> 1);
         p.fused_heading = fh;
         expected_poses.push_back(p);
      endfunction

      function void check_response(pose_beat_type got);
         pose_beat_type want;
         checked++;
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at %0t", $time);
            return;
         end
         want = expected_poses.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("pose mismatch at %0t on response %0d", $time, checked);
               $display("  odo x/y/h   exp %0d %0d %0d got %0d %0d %0d",
                        want.odo_x, want.odo_y, want.odo_heading,
                        got.odo_x, got.odo_y, got.odo_heading);
               $display("  fused x/y/h exp %0d %0d %0d got %0d %0d %0d",
                        want.fused_x, want.fused_y, want.fused_heading,
                        got.fused_x, got.fused_y, got.fused_heading);
            end
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid, req_ready;
   logic signed [31:0] req_left_angle, req_right_angle;
   logic [6:0]         req_gps_a_quality, req_gps_b_quality;
   logic signed [31:0] req_gps_a_x, req_gps_a_y, req_gps_b_x, req_gps_b_y;
   logic [15:0]        req_imu_heading;
   logic               rsp_valid, rsp_ready;
   logic signed [31:0] rsp_odo_x, rsp_odo_y, rsp_fused_x, rsp_fused_y;
   logic [15:0]        rsp_odo_heading, rsp_fused_heading;

   pose_scoreboard sb = new();
   // Encoder positions last sent, so that most beats move by a modest amount.
   logic signed [31:0] enc_left = 0, enc_right = 0;
   // When set, both sides run without idle cycles for a stretch.
   bit                 burst = 0;
   int                 sent = 0;

   wheel_odometry_with_sensor_fusion u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // All inputs start known; reset is asserted at the start and then released
   // for the rest of the run.
   initial begin
      reset = 1;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_valid = 0;
      {req_left_angle, req_right_angle, req_gps_a_x, req_gps_a_y} = '0;
      {req_gps_b_x, req_gps_b_y, req_imu_heading} = '0;
      req_gps_a_quality = '0; req_gps_b_quality = '0;
      rsp_ready = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
   end

   // Monitor: every handshake is sampled at the edge where it happens, before
   // any of that edge's nonblocking updates land.
   always @(posedge clock) begin
      sensor_beat_type b;
      pose_beat_type   p;
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            b = '{req_left_angle, req_right_angle, req_gps_a_quality, req_gps_a_x,
                  req_gps_a_y, req_gps_b_quality, req_gps_b_x, req_gps_b_y,
                  req_imu_heading};
            sb.note_request(b);
         end
         if (rsp_valid && rsp_ready) begin
            p = '{rsp_odo_x, rsp_odo_y, rsp_odo_heading, rsp_fused_x, rsp_fused_y,
                  rsp_fused_heading};
            sb.check_response(p);
         end
      end
   end

   // Response side: a random stall before each beat, none during bursts.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         n = burst ? 0 : $urandom_range(17);
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Sends one sensor beat. Valid is only lowered when a gap follows, so it
   // never gets two assignments at one edge.
   task automatic send_beat(sensor_beat_type b);
      int gap;
      gap = burst ? 0 : $urandom_range(17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1;
      req_left_angle    <= b.left_angle;
      req_right_angle   <= b.right_angle;
      req_gps_a_quality <= b.qa;
      req_gps_a_x       <= b.ax;
      req_gps_a_y       <= b.ay;
      req_gps_b_quality <= b.qb;
      req_gps_b_x       <= b.bx;
      req_gps_b_y       <= b.by;
      req_imu_heading   <= b.imu;
      do @(posedge clock); while (!req_ready);
      enc_left  = b.left_angle;
      enc_right = b.right_angle;
      sent++;
   endtask

   // Lowers valid and waits until every expected pose has come back, which
   // also leaves the block idle since each beat gives exactly one response.
   task automatic drain;
      req_valid <= 0;
      while (sb.expected_poses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic sensor_beat_type random_beat();
      sensor_beat_type b;
      int sel, step;
      sel = $urandom_range(99);
      if (sel < 15) begin
         // Occasional full-range encoder values, which saturate travel.
         b.left_angle  = $urandom;
         b.right_angle = $urandom;
      end else if (sel < 35) begin
         // Equal travel: a straight move along the current heading.
         step = $urandom_range(8000) - 4000;
         b.left_angle  = enc_left + step;
         b.right_angle = enc_right + step;
      end else begin
         b.left_angle  = enc_left + ($urandom_range(8000) - 4000);
         b.right_angle = enc_right + ($urandom_range(8000) - 4000);
      end
      b.qa = 7'($urandom_range(127));
      b.qb = ($urandom_range(3) == 0) ? 7'(b.qa + $urandom_range(2) - 1)
                                      : 7'($urandom_range(127));
      b.ax = $urandom; b.ay = $urandom;
      b.bx = $urandom; b.by = $urandom;
      // Inertial heading near the wrap edges a good part of the time.
      case ($urandom_range(3))
         0: b.imu = 16'($urandom_range(6000));
         1: b.imu = 16'(16'hFFFF - $urandom_range(6000));
         default: b.imu = 16'($urandom);
      endcase
      return b;
   endfunction

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(31) == 0) burst = ~burst;
         send_beat(random_beat());
      end
      burst = 0;
   endtask

   task automatic directed_run;
      sensor_beat_type b;
      b = '{0, 0, 7'd50, 32'sd1000, -32'sd1000, 7'd50, 32'sd3000, 32'sd5000, 16'd0};
      send_beat(b);                                              // no movement
      b.left_angle = 3600; b.right_angle = 3600; send_beat(b);   // straight
      b.right_angle = 7200; b.imu = 16'hFFFF; send_beat(b);      // arc to the left
      b.left_angle = 10000; b.imu = 16'h8000; send_beat(b);      // arc to the right
      b.qa = 7'd51; b.qb = 7'd50; send_beat(b);                  // qualities one apart
      b.qa = 7'd52; send_beat(b);                                // a clearly better
      b.qa = 7'd0; b.qb = 7'd127; send_beat(b);                  // b better, above 100
      b.qa = 7'd127; b.qb = 7'd127; send_beat(b);                // tie at the top
      b.qa = 7'd127; b.qb = 7'd0;
      b.ax = 32'sh7FFFFFFF; b.ay = 32'sh80000000; send_beat(b);  // extreme GPS fix
      b.bx = 32'sh80000000; b.by = 32'sh7FFFFFFF; b.qb = 7'd126; send_beat(b);
      // Large opposite travel spins the heading round past the wrap.
      for (int i = 0; i < 6; i++) begin
         b.left_angle  = b.left_angle - 20000;
         b.right_angle = b.right_angle + 20000;
         b.imu = (i % 2) ? 16'd1000 : 16'd64500;
         send_beat(b);
      end
      // Encoder extremes: travel saturates and the pose runs into its limits.
      b.left_angle = 32'sh7FFFFFFF; b.right_angle = 32'sh7FFFFFFF; send_beat(b);
      b.left_angle = 32'sh80000000; b.right_angle = 32'sh80000000; send_beat(b);
      b.left_angle = 32'sh7FFFFFFF; b.right_angle = 32'sh80000000; send_beat(b);
      b.left_angle = 32'sh80000000; b.right_angle = 32'sh7FFFFFFF; send_beat(b);
      b.imu = 16'd30000; send_beat(b);
   endtask

   initial begin
      int waited;
      @(negedge reset);
      @(posedge clock);
      directed_run();
      random_run(250);
      drain();
      // Zero track sum: every beat must move straight.
      write_csr(CSR_LEFT_HALF_TRACK, 16'd0);
      write_csr(CSR_RIGHT_HALF_TRACK, 16'd0);
      random_run(120);
      drain();
      // Everything at full scale, plus a write to the unused index.
      write_csr(CSR_LEFT_HALF_TRACK, 16'hFFFF);
      write_csr(CSR_RIGHT_HALF_TRACK, 16'hFFFF);
      write_csr(CSR_WHEEL_CIRC, 16'hFFFF);
      write_csr(CSR_UNUSED, 16'h0000);
      random_run(200);
      drain();
      // No wheel travel at all, and one-sided tracks.
      write_csr(CSR_WHEEL_CIRC, 16'd0);
      write_csr(CSR_LEFT_HALF_TRACK, 16'd0);
      random_run(80);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_LEFT_HALF_TRACK, 16'($urandom_range(4000)));
         write_csr(CSR_RIGHT_HALF_TRACK, 16'($urandom));
         write_csr(CSR_WHEEL_CIRC, 16'($urandom_range(1000, 12000)));
         write_csr(CSR_UNUSED, 16'($urandom));
         random_run(140);
         drain();
      end
      waited = 0;
      while (sb.expected_poses.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (800) @(posedge clock);
      if (sb.expected_poses.size() != 0) sb.mismatches += sb.expected_poses.size();
      $display("Sent %0d sensor beats across eight track settings; %0d responses checked,",
               sent, sb.checked);
      $display("%0d straight moves and %0d arcs, %0d mismatches.",
               sb.straights, sb.arcs, sb.mismatches);
      if (sb.mismatches == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #60ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
